### design/signed_decimal_digit_adder_top_defines.svh
// Assertion macros for the signed decimal digit adder checker.
// Each macro expands to one labeled concurrent assertion on clk, disabled during reset.
`ifndef SIGNED_DECIMAL_DIGIT_ADDER_TOP_DEFINES_SVH
`define SIGNED_DECIMAL_DIGIT_ADDER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SDDA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SDDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sdda_pkg.sv
// Shared constants and item types for the signed decimal digit adder.
// No dependencies; used by the datapath core and the top level.
package sdda_pkg;

  localparam int FIELD_DIGITS = 10;
  localparam int DIGITS       = 10;
  // Digits actually processed: clamped to what the 40-bit fields hold, at least one.
  localparam int LANES = (DIGITS > FIELD_DIGITS) ? FIELD_DIGITS :
                         ((DIGITS < 1) ? 1 : DIGITS);
  localparam int LANE_BITS = 4 * LANES;
  localparam int MAG_W     = 4 * FIELD_DIGITS;

  localparam logic [MAG_W-1:0] LANE_MASK = (MAG_W'(1) << LANE_BITS) - MAG_W'(1);

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [4:0] RADIX     = 5'd10;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic [MAG_W-1:0] b_digits;
    logic             b_negative;
    logic [MAG_W-1:0] a_digits;
    logic             a_negative;
  } in_item_t;

  typedef struct packed {
    logic             bad_digit;
    logic             carry_out;
    logic [MAG_W-1:0] sum_digits;
    logic             sum_negative;
  } out_item_t;

endpackage

### design/sdda_core.sv
// Combinational sign-magnitude BCD add/subtract for one item.
// Depends on sdda_pkg for the lane count, masks and item types.
module sdda_core
  import sdda_pkg::*;
(
  input  in_item_t  item_i,
  output out_item_t res_o
);

  logic [MAG_W-1:0] a_m;
  logic [MAG_W-1:0] b_m;
  logic [MAG_W-1:0] big;
  logic [MAG_W-1:0] sml;
  logic [MAG_W-1:0] add_res;
  logic [MAG_W-1:0] sub_res;
  logic [MAG_W-1:0] mag;
  logic             bad;
  logic             a_lt_b;
  logic             neg;
  logic [LANES-1:0] add_g;
  logic [LANES-1:0] add_p;
  logic [LANES-1:0] sub_g;
  logic [LANES-1:0] sub_p;
  logic [LANES:0]   add_cy;
  logic [LANES:0]   sub_bw;
  logic [4:0]       add_s   [LANES];
  logic [4:0]       add_adj [LANES];
  logic [4:0]       sub_d   [LANES];
  logic [4:0]       sub_adj [LANES];

  always_comb begin
    a_m = item_i.a_digits & LANE_MASK;
    b_m = item_i.b_digits & LANE_MASK;

    bad = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (a_m[4*i +: 4] > DIGIT_MAX || b_m[4*i +: 4] > DIGIT_MAX) begin
        bad = 1'b1;
      end
    end

    // With nibbles aligned, a plain unsigned compare orders the magnitudes
    // exactly as a digit-by-digit scan from the top would.
    a_lt_b = (a_m < b_m);
    big    = a_lt_b ? b_m : a_m;
    sml    = a_lt_b ? a_m : b_m;

    // Per-digit generate and propagate for the decimal carry and borrow.
    for (int i = 0; i < LANES; i++) begin
      add_s[i] = {1'b0, a_m[4*i +: 4]} + {1'b0, b_m[4*i +: 4]};
      add_g[i] = (add_s[i] > 5'd9);
      add_p[i] = (add_s[i] == 5'd9);
      sub_g[i] = (big[4*i +: 4] < sml[4*i +: 4]);
      sub_p[i] = (big[4*i +: 4] == sml[4*i +: 4]);
    end

    add_cy[0] = 1'b0;
    sub_bw[0] = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      add_cy[i+1] = add_g[i] | (add_p[i] & add_cy[i]);
      sub_bw[i+1] = sub_g[i] | (sub_p[i] & sub_bw[i]);
    end

    add_res = '0;
    sub_res = '0;
    for (int i = 0; i < LANES; i++) begin
      add_adj[i] = add_s[i] + {4'd0, add_cy[i]};
      if (add_adj[i] > 5'd9) begin
        add_adj[i] = add_adj[i] - RADIX;
      end
      add_res[4*i +: 4] = add_adj[i][3:0];

      sub_d[i] = {1'b0, big[4*i +: 4]} - {1'b0, sml[4*i +: 4]} - {4'd0, sub_bw[i]};
      sub_adj[i] = sub_d[i][4] ? (sub_d[i] + RADIX) : sub_d[i];
      sub_res[4*i +: 4] = sub_adj[i][3:0];
    end

    if (item_i.a_negative == item_i.b_negative) begin
      mag = add_res;
      neg = item_i.a_negative;
    end else begin
      mag = sub_res;
      neg = a_lt_b ? item_i.b_negative : item_i.a_negative;
    end

    if (bad) begin
      res_o.sum_negative = 1'b0;
      res_o.sum_digits   = '0;
      res_o.carry_out    = 1'b0;
      res_o.bad_digit    = 1'b1;
    end else begin
      res_o.sum_negative = neg & (mag != '0);
      res_o.sum_digits   = mag;
      res_o.carry_out    = (item_i.a_negative == item_i.b_negative) & add_cy[LANES];
      res_o.bad_digit    = 1'b0;
    end
  end

endmodule

### design/signed_decimal_digit_adder_top.sv
// Signed decimal digit adder: input register, combinational BCD datapath, result register.
// An accepted item waits in the input register until the result register is free to take it.
// One item per cycle while out_tready is high; the decimal carry chain in sdda_core sets fmax.
// While a result waits, the input stage takes one more item and then drops in_tready.
// Reset (rst_n low, synchronous) empties both stages; the data registers are not reset.
module signed_decimal_digit_adder_top
  import sdda_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0 up: a_negative, a_digits[39:0], b_negative, b_digits[39:0], zero pad.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0 up: sum_negative, sum_digits[39:0], carry_out, bad_digit, zero pad.
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  in_item_t  in_r;
  in_item_t  in_nxt;
  logic      in_v_r;
  logic      in_v_nxt;
  out_item_t res;
  out_item_t out_r;
  logic      out_v_r;
  logic      out_v_nxt;
  logic      in_acc;
  logic      advance;

  sdda_core u_core (
    .item_i (in_r),
    .res_o  (res)
  );

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_nxt.a_negative = in_tdata[0];
    in_nxt.a_digits   = in_tdata[MAG_W:1];
    in_nxt.b_negative = in_tdata[MAG_W+1];
    in_nxt.b_digits   = in_tdata[2*MAG_W+1:MAG_W+2];

    in_v_nxt = in_acc || (in_v_r && !advance);

    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_nxt;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(out_item_t))'(0), out_r};

endmodule

### design/sdda_checker.sv
// Port-level assertions for signed_decimal_digit_adder_top, attached by bind.
// Depends on sdda_pkg and the assertion macros in signed_decimal_digit_adder_top_defines.svh.
`include "signed_decimal_digit_adder_top_defines.svh"

module sdda_checker
  import sdda_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result stays offered and unchanged.
  `SDDA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // The input only stalls behind a result that is being held off.
  `SDDA_ASSERT_SAME(a_in_stall, !in_tready, out_tvalid && !out_tready, "input stalled without a held result")

  // A bad digit clears every other result field.
  `SDDA_ASSERT_SAME(a_bad_clears, out_tvalid && out_tdata[MAG_W+2], out_tdata[MAG_W+1:0] == '0, "bad digit result not cleared")

  // A zero magnitude is always reported as positive.
  `SDDA_ASSERT_SAME(a_zero_pos, out_tvalid && (out_tdata[MAG_W:1] == '0), !out_tdata[0], "negative zero result")

  // An overflow is only possible on a valid addition, never with a bad digit.
  `SDDA_ASSERT_SAME(a_carry_ok, out_tvalid && out_tdata[MAG_W+1], !out_tdata[MAG_W+2], "carry with bad digit")

endmodule

bind signed_decimal_digit_adder_top sdda_checker u_sdda_checker (.*);

### tb/tb_signed_decimal_digit_adder_top.sv
// Self-checking testbench for signed_decimal_digit_adder_top.
// Depends on sdda_pkg for widths, item layouts and digit constants; drives both
// streams with random idling and checks every result against a built-in predictor or a directed row's sum.
module tb_signed_decimal_digit_adder_top;
  import sdda_pkg::*;

  localparam int NUM_RANDOM     = 1000;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 200;
  localparam int BURST_ITEMS    = 40;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 40;
  localparam int DIR_ROWS       = 18;

  typedef struct packed {
    logic             a_negative;
    logic [MAG_W-1:0] a_digits;
    logic             b_negative;
    logic [MAG_W-1:0] b_digits;
    logic             typed;
    out_item_t        want;
  } dir_row_t;

  localparam out_item_t ZERO_SUM = '{1'b0, 1'b0, MAG_W'(0), 1'b0};
  localparam out_item_t BAD_SUM  = '{1'b1, 1'b0, MAG_W'(0), 1'b0};

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  out_item_t sum_queue[$];
  int        mismatches   = 0;
  int        idle_cycles  = 0;
  bit        hold_pending = 1'b0;
  bit        no_idle      = 1'b0;
  out_item_t got_sum;
  out_item_t want_sum;

  // Extremes, both operations, bad digits, signed zero and the wrap to zero.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{1'b0, 40'h0000000000, 1'b0, 40'h0000000000, 1'b1, ZERO_SUM},
    '{1'b0, 40'h9999999999, 1'b0, 40'h0000000001, 1'b1, '{1'b0, 1'b1, MAG_W'(0), 1'b0}},
    '{1'b1, 40'h9999999999, 1'b1, 40'h9999999999, 1'b1,
      '{1'b0, 1'b1, 40'h9999999998, 1'b1}},
    '{1'b0, 40'h1234567890, 1'b1, 40'h1234567890, 1'b1, ZERO_SUM},
    '{1'b1, 40'h0000000000, 1'b1, 40'h0000000000, 1'b1, ZERO_SUM},
    '{1'b0, 40'h000000000A, 1'b0, 40'h0000000000, 1'b1, BAD_SUM},
    '{1'b1, 40'h0000000000, 1'b1, 40'hF000000000, 1'b1, BAD_SUM},
    '{1'b0, 40'hFFFFFFFFFF, 1'b1, 40'hFFFFFFFFFF, 1'b1, BAD_SUM},
    '{1'b1, 40'hC000000000, 1'b0, 40'h0000000005, 1'b1, BAD_SUM},
    '{1'b0, 40'h9999999999, 1'b1, 40'h0000000000, 1'b1,
      '{1'b0, 1'b0, 40'h9999999999, 1'b0}},
    '{1'b1, 40'h0000000001, 1'b0, 40'h9999999999, 1'b0, ZERO_SUM},
    '{1'b0, 40'h5000000000, 1'b1, 40'h4999999999, 1'b0, ZERO_SUM},
    '{1'b1, 40'h0000000123, 1'b0, 40'h0000000456, 1'b0, ZERO_SUM},
    '{1'b0, 40'h0000000456, 1'b1, 40'h0000000123, 1'b0, ZERO_SUM},
    '{1'b1, 40'h1000000000, 1'b0, 40'h0999999999, 1'b0, ZERO_SUM},
    '{1'b0, 40'h0000000099, 1'b0, 40'h0000000001, 1'b0, ZERO_SUM},
    '{1'b0, 40'h5555555555, 1'b0, 40'h4444444445, 1'b0, ZERO_SUM},
    '{1'b1, 40'h0000000009, 1'b0, 40'h0000000009, 1'b0, ZERO_SUM}
  };

  signed_decimal_digit_adder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic out_item_t predict_sum(in_item_t it);
    out_item_t        r;
    logic [MAG_W-1:0] big;
    logic [MAG_W-1:0] sml;
    int unsigned      d;
    int unsigned      carry;
    int unsigned      borrow;
    int unsigned      top;
    int unsigned      sub;
    int               cmp;
    bit               bad;
    r     = '0;
    bad   = 1'b0;
    carry = 0;
    for (int i = 0; i < LANES; i++) begin
      if (it.a_digits[4*i +: 4] > DIGIT_MAX || it.b_digits[4*i +: 4] > DIGIT_MAX) bad = 1'b1;
    end
    if (bad) begin
      r.bad_digit = 1'b1;
      return r;
    end
    if (it.a_negative == it.b_negative) begin
      for (int i = 0; i < LANES; i++) begin
        d = it.a_digits[4*i +: 4] + it.b_digits[4*i +: 4] + carry;
        carry = 0;
        if (d > DIGIT_MAX) begin
          d = d - RADIX;
          carry = 1;
        end
        r.sum_digits[4*i +: 4] = d[3:0];
      end
      r.sum_negative = it.a_negative;
    end else begin
      // The first differing digit from the top decides which magnitude is larger.
      cmp = 0;
      for (int i = LANES - 1; i >= 0; i--) begin
        if (cmp == 0) begin
          if (it.a_digits[4*i +: 4] > it.b_digits[4*i +: 4]) cmp = 1;
          else if (it.a_digits[4*i +: 4] < it.b_digits[4*i +: 4]) cmp = -1;
        end
      end
      big = (cmp < 0) ? it.b_digits : it.a_digits;
      sml = (cmp < 0) ? it.a_digits : it.b_digits;
      r.sum_negative = (cmp < 0) ? it.b_negative : it.a_negative;
      borrow = 0;
      for (int i = 0; i < LANES; i++) begin
        top = big[4*i +: 4];
        sub = sml[4*i +: 4] + borrow;
        if (top < sub) begin
          d = top + RADIX - sub;
          borrow = 1;
        end else begin
          d = top - sub;
          borrow = 0;
        end
        r.sum_digits[4*i +: 4] = d[3:0];
      end
    end
    if (r.sum_digits == '0) r.sum_negative = 1'b0;
    r.carry_out = carry[0];
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] rand_bcd(int ndig);
    logic [MAG_W-1:0] v;
    v = '0;
    for (int i = 0; i < ndig; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_field(string name, logic [MAG_W-1:0] want, logic [MAG_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Offers one item and waits for it to be taken; the expected sum is queued on acceptance.
  task automatic drive_item(in_item_t it, bit typed, out_item_t want, int gap);
    in_tdata  <= IN_TDATA_W'(it);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sum_queue.push_back(typed ? want : predict_sum(it));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    in_item_t it;
    int       cat;
    int       k;
    int       pos;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      it.a_negative = directed_rows[i].a_negative;
      it.a_digits   = directed_rows[i].a_digits;
      it.b_negative = directed_rows[i].b_negative;
      it.b_digits   = directed_rows[i].b_digits;
      drive_item(it, directed_rows[i].typed, directed_rows[i].want, rand_gap());
    end

    // Open with a long receiver stall while items keep coming back to back.
    hold_pending = 1'b1;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      it.a_negative = 1'($urandom_range(0, 1));
      it.b_negative = 1'($urandom_range(0, 1));
      it.a_digits   = rand_bcd($urandom_range(1, FIELD_DIGITS));
      it.b_digits   = rand_bcd($urandom_range(1, FIELD_DIGITS));
      cat = $urandom_range(0, 99);
      if (cat < 5) begin
        pos = $urandom_range(0, FIELD_DIGITS - 1);
        if ($urandom_range(0, 1)) it.a_digits[4*pos +: 4] = 4'($urandom_range(10, 15));
        else it.b_digits[4*pos +: 4] = 4'($urandom_range(10, 15));
      end else if (cat < 10) begin
        it.a_digits = {8'($urandom), $urandom};
        it.b_digits = {8'($urandom), $urandom};
      end else if (cat < 20) begin
        it.a_digits   = rand_bcd(FIELD_DIGITS);
        it.b_digits   = it.a_digits;
        it.b_negative = ~it.a_negative ^ ($urandom_range(0, 3) == 0);
      end else if (cat < 35) begin
        // Shared upper digits push the magnitude compare deep into the word.
        it.a_digits = rand_bcd(FIELD_DIGITS);
        k = $urandom_range(1, FIELD_DIGITS);
        it.b_digits = it.a_digits;
        for (int i = 0; i < k; i++) it.b_digits[4*i +: 4] = 4'($urandom_range(0, 9));
      end else if (cat < 45) begin
        it.a_digits = rand_bcd(FIELD_DIGITS);
        it.b_digits = rand_bcd(FIELD_DIGITS);
      end
      drive_item(it, 1'b0, ZERO_SUM, (n < BURST_ITEMS) ? 0 : rand_gap());
    end
    in_tvalid <= 1'b0;

    while (sum_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int g;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        g = rand_gap();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got_sum = out_tdata[$bits(out_item_t)-1:0];
        if (sum_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected item, expected none, got %h", $time, got_sum);
        end else begin
          want_sum = sum_queue.pop_front();
          report_field("sum_negative", MAG_W'(want_sum.sum_negative),
                       MAG_W'(got_sum.sum_negative));
          report_field("sum_digits", want_sum.sum_digits, got_sum.sum_digits);
          report_field("carry_out", MAG_W'(want_sum.carry_out), MAG_W'(got_sum.carry_out));
          report_field("bad_digit", MAG_W'(want_sum.bad_digit), MAG_W'(got_sum.bad_digit));
        end
      end
    end
  end

endmodule
